/* rtl/core/jqc_pkg.sv */
// Shared constants, types and pointer helpers for the job queue with cancel.
`timescale 1ns / 1ps

package jqc_pkg;

   // Queue geometry.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W = 16;
   localparam int PAGE_W = 12;
   localparam int TOTAL_W = 16;
   localparam int COUNT_W = 5;

   // Exact page sum never overflows: DEPTH entries of at most 4095 pages.
   localparam int SUM_W = PAGE_W + IDX_W;
   localparam int SUM_WIDE_W = SUM_W + TOTAL_W;
   localparam int CNT_WIDE_W = OCC_W + COUNT_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_ID_ADDR = 2'd0;
   localparam logic [ID_W-1:0] START_ID_RESET = 16'd100;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PROCESS = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;

   // One stored job.
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [PAGE_W-1:0] pages;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic enq;
      logic begin_read;
      logic scan_step;
      logic pop;
      logic remove;
      logic fail;
      logic [STATUS_W-1:0] fail_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic hit;
      logic found;
      logic last;
   } flags_type;

   // Ring pointer step forwards, wrapping at DEPTH.
   function automatic idx_type ptr_inc(input idx_type a);
      idx_type r;
      if (a == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + IDX_W'(1);
      end
      return r;
   endfunction

   // Ring pointer step backwards, wrapping at DEPTH.
   function automatic idx_type ptr_dec(input idx_type a);
      idx_type r;
      if (a == '0) begin
         r = IDX_W'(DEPTH - 1);
      end else begin
         r = a - IDX_W'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/core/jqc_ctrl.sv */
// Controller state machine that sequences enqueue, process and remove transactions.
`timescale 1ns / 1ps

module jqc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jqc_pkg::ACTION_W-1:0]  req_action,
   input  jqc_pkg::flags_type            flags,
   output logic                          busy,
   output jqc_pkg::cmd_type              cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.fail_status = jqc_pkg::STS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  jqc_pkg::ACT_ENQUEUE: begin
                     if (flags.full) begin
                        cmd.fail = 1'b1;
                        cmd.fail_status = jqc_pkg::STS_FULL;
                     end else begin
                        cmd.enq = 1'b1;
                     end
                  end
                  jqc_pkg::ACT_PROCESS: begin
                     if (flags.empty) begin
                        cmd.fail = 1'b1;
                        cmd.fail_status = jqc_pkg::STS_EMPTY;
                     end else begin
                        cmd.begin_read = 1'b1;
                        state_in = ST_POP;
                     end
                  end
                  jqc_pkg::ACT_REMOVE: begin
                     if (flags.empty) begin
                        cmd.fail = 1'b1;
                        cmd.fail_status = jqc_pkg::STS_EMPTY;
                     end else begin
                        cmd.begin_read = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     // Unused action: report the unchanged queue.
                     cmd.fail = 1'b1;
                     cmd.fail_status = jqc_pkg::STS_OK;
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.pop = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (flags.last) begin
               if (flags.found || flags.hit) begin
                  cmd.remove = 1'b1;
               end else begin
                  cmd.fail = 1'b1;
                  cmd.fail_status = jqc_pkg::STS_NOT_FOUND;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/core/jqc_datapath.sv */
// Datapath: ring-buffer job store, pointers, counters, page sum and result registers.
`timescale 1ns / 1ps

module jqc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  jqc_pkg::cmd_type               cmd,
   output jqc_pkg::flags_type             flags,
   input  logic [jqc_pkg::PAGE_W-1:0]     req_page_count,
   input  logic [jqc_pkg::ID_W-1:0]       req_target_id,
   input  logic                           cfg_wr,
   input  logic [jqc_pkg::ID_W-1:0]       cfg_wdata,
   output logic [jqc_pkg::ID_W-1:0]       cfg_start_id,
   output logic                           rsp_valid,
   output logic [jqc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [jqc_pkg::ID_W-1:0]       rsp_job_id,
   output logic [jqc_pkg::PAGE_W-1:0]     rsp_job_pages,
   output logic [jqc_pkg::TOTAL_W-1:0]    rsp_total_pages,
   output logic [jqc_pkg::COUNT_W-1:0]    rsp_entry_count
);

   // Job store.
   jqc_pkg::entry_type mem [jqc_pkg::DEPTH];
   jqc_pkg::entry_type rd_data_ff;
   logic               mem_we;
   jqc_pkg::idx_type   mem_waddr;
   jqc_pkg::idx_type   mem_raddr;
   jqc_pkg::entry_type mem_wdata;

   // Queue control state.
   jqc_pkg::idx_type head_ff, head_in;
   jqc_pkg::idx_type tail_ff, tail_in;
   logic [jqc_pkg::OCC_W-1:0] occ_ff, occ_in;
   logic [jqc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [jqc_pkg::ID_W-1:0] next_num_ff, next_num_in;
   logic [jqc_pkg::ID_W-1:0] start_id_ff, start_id_in;

   // Scan state.
   jqc_pkg::idx_type ptr_ff, ptr_in;
   jqc_pkg::idx_type k_ff, k_in;
   logic found_ff, found_in;
   jqc_pkg::entry_type hit_ff, hit_in;
   logic [jqc_pkg::ID_W-1:0] target_ff, target_in;

   // Result registers.
   logic rsp_valid_ff, rsp_valid_in;
   logic [jqc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [jqc_pkg::ID_W-1:0] job_id_ff, job_id_in;
   logic [jqc_pkg::PAGE_W-1:0] job_pages_ff, job_pages_in;

   jqc_pkg::entry_type removed;
   logic [jqc_pkg::SUM_WIDE_W-1:0] sum_wide;
   logic [jqc_pkg::CNT_WIDE_W-1:0] cnt_wide;

   // Status towards the controller.
   always_comb begin
      flags.full = (occ_ff == jqc_pkg::OCC_W'(jqc_pkg::DEPTH));
      flags.empty = (occ_ff == '0);
      flags.hit = (rd_data_ff.id == target_ff);
      flags.found = found_ff;
      flags.last = (occ_ff == (jqc_pkg::OCC_W'(k_ff) + jqc_pkg::OCC_W'(1)));
   end

   // The job being removed was either captured earlier or is the one just read.
   assign removed = found_ff ? hit_ff : rd_data_ff;

   // Next-state logic for all datapath registers.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      sum_in = sum_ff;
      next_num_in = next_num_ff;
      start_id_in = start_id_ff;
      ptr_in = ptr_ff;
      k_in = k_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      target_in = target_ff;
      rsp_valid_in = 1'b0;
      status_in = status_ff;
      job_id_in = job_id_ff;
      job_pages_in = job_pages_ff;
      mem_we = 1'b0;
      mem_waddr = tail_ff;
      mem_wdata.id = next_num_ff;
      mem_wdata.pages = req_page_count;
      mem_raddr = cmd.begin_read ? head_ff : jqc_pkg::ptr_inc(ptr_ff);

      // Configuration write restarts the numbering.
      if (cfg_wr) begin
         start_id_in = cfg_wdata;
         next_num_in = cfg_wdata;
      end

      // Enqueue at the tail.
      if (cmd.enq) begin
         mem_we = 1'b1;
         tail_in = jqc_pkg::ptr_inc(tail_ff);
         occ_in = occ_ff + jqc_pkg::OCC_W'(1);
         sum_in = sum_ff + jqc_pkg::SUM_W'(req_page_count);
         next_num_in = next_num_ff + jqc_pkg::ID_W'(1);
         rsp_valid_in = 1'b1;
         status_in = jqc_pkg::STS_OK;
         job_id_in = next_num_ff;
         job_pages_in = req_page_count;
      end

      // Start reading from the oldest job.
      if (cmd.begin_read) begin
         ptr_in = head_ff;
         k_in = '0;
         found_in = 1'b0;
         target_in = req_target_id;
      end

      // One entry per cycle: find the first match, then move later entries down.
      if (cmd.scan_step) begin
         ptr_in = jqc_pkg::ptr_inc(ptr_ff);
         k_in = k_ff + jqc_pkg::IDX_W'(1);
         if (found_ff) begin
            mem_we = 1'b1;
            mem_waddr = jqc_pkg::ptr_dec(ptr_ff);
            mem_wdata = rd_data_ff;
         end else if (flags.hit) begin
            found_in = 1'b1;
            hit_in = rd_data_ff;
         end
      end

      // Pop the oldest job.
      if (cmd.pop) begin
         head_in = jqc_pkg::ptr_inc(head_ff);
         occ_in = occ_ff - jqc_pkg::OCC_W'(1);
         sum_in = sum_ff - jqc_pkg::SUM_W'(rd_data_ff.pages);
         rsp_valid_in = 1'b1;
         status_in = jqc_pkg::STS_OK;
         job_id_in = rd_data_ff.id;
         job_pages_in = rd_data_ff.pages;
      end

      // Close the removal: the queue is one shorter at the tail.
      if (cmd.remove) begin
         tail_in = jqc_pkg::ptr_dec(tail_ff);
         occ_in = occ_ff - jqc_pkg::OCC_W'(1);
         sum_in = sum_ff - jqc_pkg::SUM_W'(removed.pages);
         rsp_valid_in = 1'b1;
         status_in = jqc_pkg::STS_OK;
         job_id_in = removed.id;
         job_pages_in = removed.pages;
      end

      // Failed or no-op transaction: no job involved.
      if (cmd.fail) begin
         rsp_valid_in = 1'b1;
         status_in = cmd.fail_status;
         job_id_in = '0;
         job_pages_in = '0;
      end
   end

   // Job store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff <= '0;
         sum_ff <= '0;
         next_num_ff <= jqc_pkg::START_ID_RESET;
         start_id_ff <= jqc_pkg::START_ID_RESET;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
         sum_ff <= sum_in;
         next_num_ff <= next_num_in;
         start_id_ff <= start_id_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      k_ff <= k_in;
      hit_ff <= hit_in;
      target_ff <= target_in;
      status_ff <= status_in;
      job_id_ff <= job_id_in;
      job_pages_ff <= job_pages_in;
   end

   // Page total saturates at the output width; count is masked to its width.
   assign sum_wide = jqc_pkg::SUM_WIDE_W'(sum_ff);
   assign cnt_wide = jqc_pkg::CNT_WIDE_W'(occ_ff);
   assign rsp_total_pages = (|sum_wide[jqc_pkg::SUM_WIDE_W-1:jqc_pkg::TOTAL_W]) ?
                            {jqc_pkg::TOTAL_W{1'b1}} : sum_wide[jqc_pkg::TOTAL_W-1:0];
   assign rsp_entry_count = cnt_wide[jqc_pkg::COUNT_W-1:0];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_job_id = job_id_ff;
   assign rsp_job_pages = job_pages_ff;
   assign cfg_start_id = start_id_ff;

endmodule

/* rtl/core/job_queue_with_cancel.sv */
// Top level of the bounded job queue with enqueue, process-oldest and remove-by-number.
//
// Usage: a transaction is accepted at a rising edge with start high and busy low; it
// carries req_action, req_page_count and req_target_id. Exactly one result follows,
// shown for one cycle with rsp_valid high, carrying status, job number, job pages,
// the page total and the entry count after the transaction.
// Enqueue, failed or unused actions show their result in the cycle after acceptance;
// process reads the oldest job from the job store, then pops it in the pop state;
// remove scans every queued job in the scan state before its result is registered.
// Busy stays high while process or remove runs, so one transaction is in flight at
// a time; the remove scan goes through the job store's one read port, one entry per
// cycle, and so makes remove the longest transaction.
// A new transaction may be accepted in the same cycle as the previous result.
// The receiver cannot stall: each result is taken in its one valid cycle.
// Reset empties the queue, clears the page total and loads the job numbering and
// start_job_id register with 100; the job store itself needs no clearing pass.
// The user must write the start_job_id register at address 0 (APB-style port) only
// while the queue is idle, unenforced by the block; a write restarts job numbering at it.
`timescale 1ns / 1ps

module job_queue_with_cancel (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [jqc_pkg::ACTION_W-1:0]      req_action,
   input  logic [jqc_pkg::PAGE_W-1:0]        req_page_count,
   input  logic [jqc_pkg::ID_W-1:0]          req_target_id,
   output logic                              rsp_valid,
   output logic [jqc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [jqc_pkg::ID_W-1:0]          rsp_job_id,
   output logic [jqc_pkg::PAGE_W-1:0]        rsp_job_pages,
   output logic [jqc_pkg::TOTAL_W-1:0]       rsp_total_pages,
   output logic [jqc_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [jqc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [jqc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [jqc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   jqc_pkg::cmd_type   cmd;
   jqc_pkg::flags_type flags;
   logic               cfg_wr;
   logic [jqc_pkg::ID_W-1:0] start_id;

   // Register decode: a write completes in the access cycle.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr == jqc_pkg::CSR_START_ID_ADDR);
   assign prdata = (paddr == jqc_pkg::CSR_START_ID_ADDR) ?
                   jqc_pkg::CSR_DATA_W'(start_id) : '0;

   jqc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .flags      (flags),
      .busy       (busy),
      .cmd        (cmd)
   );

   jqc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .flags           (flags),
      .req_page_count  (req_page_count),
      .req_target_id   (req_target_id),
      .cfg_wr          (cfg_wr),
      .cfg_wdata       (pwdata[jqc_pkg::ID_W-1:0]),
      .cfg_start_id    (start_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_job_id      (rsp_job_id),
      .rsp_job_pages   (rsp_job_pages),
      .rsp_total_pages (rsp_total_pages),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
